@@ src/dsipp_pkg.sv @@
`default_nettype none

package dsipp_pkg;

    // Lane symbol kinds
    localparam logic [1:0] SYM_SOT   = 2'd0;
    localparam logic [1:0] SYM_EOT   = 2'd1;
    localparam logic [1:0] SYM_DATA  = 2'd2;
    localparam logic [1:0] SYM_OTHER = 2'd3;

    // Result kinds
    localparam logic [2:0] K_VC     = 3'd0;
    localparam logic [2:0] K_TYPE   = 3'd1;
    localparam logic [2:0] K_LEN    = 3'd2;
    localparam logic [2:0] K_BYTE   = 3'd3;
    localparam logic [2:0] K_ECC    = 3'd4;
    localparam logic [2:0] K_CK_OK  = 3'd5;
    localparam logic [2:0] K_CK_BAD = 3'd6;
    localparam logic [2:0] K_ERR    = 3'd7;

    // Data type classes
    localparam logic [1:0] TC_UNKNOWN = 2'd0;
    localparam logic [1:0] TC_LONG    = 2'd1;
    localparam logic [1:0] TC_SHORT   = 2'd2;

    // Checksum: reflected CRC-16
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Result queue depth; two slots must be free to take an item
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        last;
    } result_t;

    // Up to two results produced by one item
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  d);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ d[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [1:0] type_class(input logic [5:0] t);
        logic [1:0] c;
        unique case (t) inside
            6'h09, 6'h19, 6'h29, 6'h39, 6'h0E, 6'h1E, 6'h2E, 6'h3E:
                c = TC_LONG;
            6'h01, 6'h11, 6'h21, 6'h31, 6'h08, 6'h02, 6'h12, 6'h22, 6'h32,
            6'h03, 6'h13, 6'h23, 6'h04, 6'h14, 6'h24, 6'h05, 6'h15, 6'h06,
            6'h37:
                c = TC_SHORT;
            default:
                c = TC_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/dsipp_core.sv @@
`default_nettype none

module dsipp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [1:0]       sym_kind,
    input  wire logic [7:0]       data_byte,
    output dsipp_pkg::push_t      push
);
    import dsipp_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HEADER = 4'd1;
    localparam logic [3:0] ST_LEN_LO = 4'd2;
    localparam logic [3:0] ST_LEN_HI = 4'd3;
    localparam logic [3:0] ST_L_ECC  = 4'd4;
    localparam logic [3:0] ST_L_DATA = 4'd5;
    localparam logic [3:0] ST_CK_LO  = 4'd6;
    localparam logic [3:0] ST_CK_HI  = 4'd7;
    localparam logic [3:0] ST_S_D0   = 4'd8;
    localparam logic [3:0] ST_S_D1   = 4'd9;
    localparam logic [3:0] ST_S_ECC  = 4'd10;
    localparam logic [3:0] ST_DROP   = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;

    logic        is_data;
    logic [15:0] seen_inc;
    logic [15:0] rx_ck;
    logic [1:0]  tclass;

    assign is_data  = (sym_kind == SYM_DATA);
    assign seen_inc = seen_reg + 16'd1;
    assign rx_ck    = {data_byte, ck_lo_reg};
    assign tclass   = type_class(data_byte[5:0]);

    // Parse one symbol: next state and up to two results
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        crc_next   = crc_reg;
        ck_lo_next = ck_lo_reg;
        push       = '0;

        unique case (state_reg)
            ST_HEADER:
            begin
                if (is_data)
                begin
                    push.r0 = '{kind: K_VC, value: {14'd0, data_byte[7:6]}, last: 1'b0};
                    push.n  = 2'd2;
                    if (tclass == TC_UNKNOWN)
                    begin
                        push.r1    = '{kind: K_ERR, value: 16'd0, last: 1'b1};
                        state_next = ST_DROP;
                    end
                    else
                    begin
                        push.r1    = '{kind: K_TYPE, value: {10'd0, data_byte[5:0]},
                                       last: 1'b1};
                        state_next = (tclass == TC_LONG) ? ST_LEN_LO : ST_S_D0;
                    end
                end
                else if (sym_kind == SYM_EOT)
                    state_next = ST_IDLE;
                else
                begin
                    push.r0    = '{kind: K_ERR, value: 16'd0, last: 1'b1};
                    push.n     = 2'd1;
                    state_next = ST_DROP;
                end
            end

            ST_LEN_LO, ST_LEN_HI, ST_L_ECC, ST_L_DATA, ST_CK_LO, ST_CK_HI,
            ST_S_D0, ST_S_D1, ST_S_ECC:
            begin
                if (!is_data)
                begin
                    push.r0    = '{kind: K_ERR, value: 16'd0, last: 1'b1};
                    push.n     = 2'd1;
                    state_next = ST_DROP;
                end
                else
                begin
                    case (state_reg)
                        ST_LEN_LO:
                        begin
                            len_next   = {8'd0, data_byte};
                            state_next = ST_LEN_HI;
                        end
                        ST_LEN_HI:
                        begin
                            len_next   = {data_byte, len_reg[7:0]};
                            push.r0    = '{kind: K_LEN, value: {data_byte, len_reg[7:0]},
                                           last: 1'b1};
                            push.n     = 2'd1;
                            state_next = ST_L_ECC;
                        end
                        ST_L_ECC:
                        begin
                            push.r0    = '{kind: K_ECC, value: {8'd0, data_byte}, last: 1'b1};
                            push.n     = 2'd1;
                            crc_next   = CRC_INIT;
                            seen_next  = 16'd0;
                            state_next = (len_reg == 16'd0) ? ST_CK_LO : ST_L_DATA;
                        end
                        ST_L_DATA:
                        begin
                            push.r0   = '{kind: K_BYTE, value: {8'd0, data_byte}, last: 1'b1};
                            push.n    = 2'd1;
                            crc_next  = crc16_byte(crc_reg, data_byte);
                            seen_next = seen_inc;
                            if (seen_inc == len_reg)
                                state_next = ST_CK_LO;
                        end
                        ST_CK_LO:
                        begin
                            ck_lo_next = data_byte;
                            state_next = ST_CK_HI;
                        end
                        ST_CK_HI:
                        begin
                            // zero checksum means "not computed" and always passes
                            if (rx_ck == crc_reg || rx_ck == 16'd0)
                                push.r0 = '{kind: K_CK_OK, value: rx_ck, last: 1'b1};
                            else
                                push.r0 = '{kind: K_CK_BAD, value: rx_ck, last: 1'b1};
                            push.n     = 2'd1;
                            state_next = ST_HEADER;
                        end
                        ST_S_D0, ST_S_D1:
                        begin
                            push.r0    = '{kind: K_BYTE, value: {8'd0, data_byte}, last: 1'b1};
                            push.n     = 2'd1;
                            state_next = (state_reg == ST_S_D0) ? ST_S_D1 : ST_S_ECC;
                        end
                        default:
                        begin
                            push.r0    = '{kind: K_ECC, value: {8'd0, data_byte}, last: 1'b1};
                            push.n     = 2'd1;
                            state_next = ST_HEADER;
                        end
                    endcase
                end
            end

            ST_DROP:
            begin
                if (sym_kind == SYM_EOT)
                    state_next = ST_IDLE;
            end

            // idle and unused codes
            default:
            begin
                state_next = (sym_kind == SYM_SOT) ? ST_HEADER : ST_IDLE;
            end
        endcase

        if (!accept)
            push.n = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= 16'd0;
            seen_reg  <= 16'd0;
            crc_reg   <= 16'd0;
            ck_lo_reg <= 8'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            crc_reg   <= crc_next;
            ck_lo_reg <= ck_lo_next;
        end
    end

endmodule

`default_nettype wire

@@ src/dsipp_queue.sv @@
`default_nettype none

module dsipp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsipp_pkg::push_t  push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dsipp_pkg::result_t     out_res
);
    import dsipp_pkg::*;

    result_t           ents_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_p1;

    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_res   = ents_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign wr_p1     = wr_reg + QPTR_W'(1);

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push.n);
        rd_next  = pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            ents_reg[wr_reg] <= push.r0;
        if (push.n == 2'd2)
            ents_reg[wr_p1] <= push.r1;
    end

endmodule

`default_nettype wire

@@ src/dsi_packet_parser.sv @@
// DSI packet parser. Takes one lane symbol per item (kind on s_axis_tuser,
// byte on s_axis_tdata) and emits decoded fields one per item on the master
// side, with tlast on the final result of each input symbol. Symbols are
// parsed in the cycle they are accepted, CRC included, so an item can be
// taken every cycle while the queue has room; results go to a four-entry
// queue that drains one per cycle while the sink is ready; if it was empty,
// the first result appears on the output the cycle after its symbol.
// A packet header gives two results, so the input is held off while fewer
// than two queue slots are free; with an always-ready sink the block sustains
// one symbol per cycle, but a header taken with two results queued stalls it.
`default_nettype none

module dsi_packet_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] sym_kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] out_value
    output logic [2:0]       m_axis_tuser,   // [2:0] out_kind
    output logic             m_axis_tlast
);
    import dsipp_pkg::*;

    push_t   push;
    result_t head;
    logic    accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    dsipp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sym_kind  (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .push      (push)
    );

    dsipp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    assign m_axis_tdata = head.value;
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

@@ src/dsipp_checker.sv @@
`default_nettype none

module dsipp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import dsipp_pkg::*;

    logic in_seen;
    assign in_seen = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Errors carry zero and close the symbol's results
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == K_ERR |-> m_axis_tdata == 16'd0 && m_axis_tlast)
        else $error("error result not zero or not last");

    // Channel result is never last (type or error follows) and holds only two bits
    a_vc_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == K_VC |->
            !m_axis_tlast && m_axis_tdata[15:2] == 14'd0)
        else $error("bad channel result");

    // Checksum verdicts are single results
    a_ck_last: assert property (@(posedge clk) disable iff (!rst_n || in_seen === 1'bx)
        m_axis_tvalid && (m_axis_tuser == K_CK_OK || m_axis_tuser == K_CK_BAD)
            |-> m_axis_tlast)
        else $error("checksum result without last");

endmodule

bind dsi_packet_parser dsipp_checker u_dsipp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
